// ===== hw/rtl/sme_pkg.sv =====
// Shared types, widths and codes of the stack machine execute block.
// Used by sme_stack_cell, sme_data_mem and stack_machine_execute_core.
`default_nettype none
package sme_pkg;

   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 4;
   localparam int PC_W          = 9;
   localparam int STATUS_W      = 3;
   localparam int COUNT_W       = 7;
   localparam int PROG_DEPTH    = 256;
   localparam int STACK_DEPTH   = 64;
   localparam int DATA_DEPTH_DEF = 256;

   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 56;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;

   localparam logic [CSR_AW-1:0] ADDR_PROGRAM_LENGTH = 3'd0;

   typedef enum logic [FUNC_W-1:0] {
      FN_RET = 4'd0,
      FN_LD  = 4'd1,
      FN_ST  = 4'd2,
      FN_LDC = 4'd3,
      FN_ADD = 4'd4,
      FN_SUB = 4'd5,
      FN_CMP = 4'd6,
      FN_JMP = 4'd7,
      FN_BR  = 4'd8
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_RUN    = 3'd0,
      ST_HALT   = 3'd1,
      ST_UNDER  = 3'd2,
      ST_ADDR   = 3'd3,
      ST_TARGET = 3'd4,
      ST_OPCODE = 3'd5,
      ST_OVER   = 3'd6
   } status_type;

   // Shift command broadcast to every stack cell
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [WORD_W-1:0] push_data;
   } stk_ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sme_stack_cell.sv =====
// One entry of the shift-register operand stack.
// Depends on sme_pkg for the word width and the shift command struct.
`default_nettype none
module sme_stack_cell (
   input  wire logic                        clock,
   input  wire sme_pkg::stk_ctl_type        ctl,
   input  wire logic [sme_pkg::WORD_W-1:0]  from_above,
   input  wire logic [sme_pkg::WORD_W-1:0]  from_below,
   output logic      [sme_pkg::WORD_W-1:0]  value
);

   logic [sme_pkg::WORD_W-1:0] value_ff;
   logic [sme_pkg::WORD_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         value_in = from_above;
      end else if (ctl.pop) begin
         value_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sme_data_mem.sv =====
// Data memory with registered read and a zero-fill sweep after reset.
// Depends on sme_pkg for the word width.
`default_nettype none
module sme_data_mem #(
   parameter int DATA_DEPTH = sme_pkg::DATA_DEPTH_DEF,
   parameter int DATA_AW    = $clog2(DATA_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [DATA_AW-1:0]          rd_addr,
   output logic      [sme_pkg::WORD_W-1:0]  rd_data,
   input  wire logic                        wr_en,
   input  wire logic [DATA_AW-1:0]          wr_addr,
   input  wire logic [sme_pkg::WORD_W-1:0]  wr_data,
   output logic                             busy
);

   logic [sme_pkg::WORD_W-1:0] mem [DATA_DEPTH];
   logic [sme_pkg::WORD_W-1:0] rd_data_ff;
   logic                       busy_ff;
   logic                       busy_in;
   logic [DATA_AW-1:0]         clr_ptr_ff;
   logic [DATA_AW-1:0]         clr_ptr_in;
   logic                       we;
   logic [DATA_AW-1:0]         waddr;
   logic [sme_pkg::WORD_W-1:0] wdata;

   always_comb begin
      busy_in    = busy_ff;
      clr_ptr_in = clr_ptr_ff;
      if (busy_ff) begin
         clr_ptr_in = clr_ptr_ff + DATA_AW'(1);
         if (clr_ptr_ff == DATA_AW'(DATA_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
      we    = busy_ff | wr_en;
      waddr = busy_ff ? clr_ptr_ff : wr_addr;
      wdata = busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_ptr_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/stack_machine_execute_core.sv =====
// Top level of the stack machine execute block: handshakes, execute stage, CSR.
// Depends on sme_pkg, sme_stack_cell and sme_data_mem.
//
//  channel | direction | beat contents (low bits first)
//  req_    | in        | func[3:0], argument[35:4]
//  rsp_    | out       | next_pc[8:0], status[11:9], top_value[43:12], stack_count[50:44]
//  csr_    | in/out    | program_length at byte address 0
//
// An instruction is registered and reads data memory on its accept edge; on its execute edge
// (b_fire) it runs against the stack cells and loads the result register.
// A new beat is accepted on the execute edge of the previous one, so one instruction
// completes every cycle while rsp_tready stays high; a stalled result holds both stages.
// After reset the data memory is zero-filled; req_tready stays low until the sweep ends.
`default_nettype none
module stack_machine_execute_core #(
   parameter int DATA_DEPTH = sme_pkg::DATA_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // func[3:0], argument[35:4], zero fill
   input  wire logic [sme_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // next_pc[8:0], status[11:9], top_value[43:12], stack_count[50:44], zero fill
   output logic      [sme_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [sme_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [sme_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic      [sme_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int DATA_AW = $clog2(DATA_DEPTH);
   localparam int WW      = sme_pkg::WORD_W;
   localparam int NCELL   = sme_pkg::STACK_DEPTH;

   // configuration
   logic [sme_pkg::PC_W-1:0] prog_len_ff;
   logic                     csr_wr;

   // fetch stage
   logic                        a_valid_ff;
   logic [sme_pkg::FUNC_W-1:0]  a_func_ff;
   logic [WW-1:0]               a_arg_ff;
   logic                        a_fwd_hit_ff;
   logic [WW-1:0]               a_fwd_data_ff;

   // architectural state
   logic [sme_pkg::PC_W-1:0]    pc_ff;
   logic                        halted_ff;
   logic [sme_pkg::COUNT_W-1:0] depth_ff;

   // result register
   logic                            rsp_valid_ff;
   logic [sme_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   logic                        accept;
   logic                        b_fire;
   logic                        mem_busy;
   logic [WW-1:0]               mem_rd;
   logic                        st_we;
   logic [WW-1:0]               cell_q [NCELL];
   sme_pkg::stk_ctl_type        stk_ctl;

   // execute results
   logic [sme_pkg::PC_W-1:0]    len;
   logic                        stepping;
   sme_pkg::status_type         status;
   logic [sme_pkg::PC_W-1:0]    npc;
   logic                        do_push;
   logic                        do_pop;
   logic [WW-1:0]               push_val;
   logic [WW-1:0]               ld_data;
   logic                        arg_in_data;
   logic                        arg_in_prog;
   logic                        depth_full;
   logic [sme_pkg::PC_W-1:0]    pc_in;
   logic                        halted_in;
   logic [sme_pkg::COUNT_W-1:0] depth_in;
   logic [WW-1:0]               top_in;
   logic                        fwd_hit_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite
                       & (csr_paddr == sme_pkg::ADDR_PROGRAM_LENGTH);
   assign csr_prdata = (csr_paddr == sme_pkg::ADDR_PROGRAM_LENGTH)
                       ? {{(sme_pkg::CSR_DW - sme_pkg::PC_W){1'b0}}, prog_len_ff} : '0;

   assign b_fire     = a_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~mem_busy & (~a_valid_ff | b_fire);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      len = (prog_len_ff > sme_pkg::PC_W'(sme_pkg::PROG_DEPTH))
            ? sme_pkg::PC_W'(sme_pkg::PROG_DEPTH) : prog_len_ff;
      arg_in_data = a_arg_ff < WW'(DATA_DEPTH);
      arg_in_prog = a_arg_ff < {{(WW - sme_pkg::PC_W){1'b0}}, len};
      depth_full  = depth_ff >= sme_pkg::COUNT_W'(NCELL);
      ld_data     = a_fwd_hit_ff ? a_fwd_data_ff : mem_rd;

      stepping = 1'b1;
      status   = sme_pkg::ST_RUN;
      npc      = pc_ff + sme_pkg::PC_W'(1);
      do_push  = 1'b0;
      do_pop   = 1'b0;
      push_val = '0;

      if (halted_ff || (pc_ff >= len)) begin
         stepping = 1'b0;
         status   = sme_pkg::ST_HALT;
      end else begin
         case (sme_pkg::func_type'(a_func_ff))
            sme_pkg::FN_RET: begin
               status = sme_pkg::ST_HALT;
            end
            sme_pkg::FN_LD: begin
               if (!arg_in_data) status = sme_pkg::ST_ADDR;
               else if (depth_full) status = sme_pkg::ST_OVER;
               else begin
                  do_push  = 1'b1;
                  push_val = ld_data;
               end
            end
            sme_pkg::FN_ST: begin
               if (!arg_in_data) status = sme_pkg::ST_ADDR;
               else if (depth_ff == '0) status = sme_pkg::ST_UNDER;
               else do_pop = 1'b1;
            end
            sme_pkg::FN_LDC: begin
               if (depth_full) status = sme_pkg::ST_OVER;
               else begin
                  do_push  = 1'b1;
                  push_val = a_arg_ff;
               end
            end
            sme_pkg::FN_ADD, sme_pkg::FN_SUB, sme_pkg::FN_CMP: begin
               if (depth_ff < sme_pkg::COUNT_W'(2)) status = sme_pkg::ST_UNDER;
               else if (depth_full) status = sme_pkg::ST_OVER;
               else begin
                  do_push = 1'b1;
                  if (sme_pkg::func_type'(a_func_ff) == sme_pkg::FN_ADD) begin
                     push_val = cell_q[0] + cell_q[1];
                  end else if (sme_pkg::func_type'(a_func_ff) == sme_pkg::FN_SUB) begin
                     push_val = cell_q[0] - cell_q[1];
                  end else if ($signed(cell_q[0]) < $signed(cell_q[1])) begin
                     push_val = '1;
                  end else if ($signed(cell_q[0]) > $signed(cell_q[1])) begin
                     push_val = WW'(1);
                  end else begin
                     push_val = '0;
                  end
               end
            end
            sme_pkg::FN_JMP: begin
               if (!arg_in_prog) status = sme_pkg::ST_TARGET;
               else npc = a_arg_ff[sme_pkg::PC_W-1:0];
            end
            sme_pkg::FN_BR: begin
               if (!arg_in_prog) status = sme_pkg::ST_TARGET;
               else if (depth_ff == '0) status = sme_pkg::ST_UNDER;
               else if (cell_q[0] != '0) npc = a_arg_ff[sme_pkg::PC_W-1:0];
            end
            default: begin
               status = sme_pkg::ST_OPCODE;
            end
         endcase
      end

      pc_in     = pc_ff;
      halted_in = halted_ff;
      if (stepping) begin
         if (status == sme_pkg::ST_RUN) pc_in = npc;
         else halted_in = 1'b1;
      end

      depth_in = depth_ff;
      top_in   = cell_q[0];
      if (do_push) begin
         depth_in = depth_ff + sme_pkg::COUNT_W'(1);
         top_in   = push_val;
      end else if (do_pop) begin
         depth_in = depth_ff - sme_pkg::COUNT_W'(1);
         top_in   = cell_q[1];
      end
      if (depth_in == '0) top_in = '0;

      stk_ctl.push      = b_fire & do_push;
      stk_ctl.pop       = b_fire & do_pop;
      stk_ctl.push_data = push_val;

      st_we      = b_fire & do_pop;
      // forward a store landing on the same edge the next load reads memory
      fwd_hit_in = st_we & (req_tdata[sme_pkg::FUNC_W +: DATA_AW] == a_arg_ff[DATA_AW-1:0]);
   end

   sme_data_mem #(
      .DATA_DEPTH (DATA_DEPTH),
      .DATA_AW    (DATA_AW)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_tdata[sme_pkg::FUNC_W +: DATA_AW]),
      .rd_data (mem_rd),
      .wr_en   (st_we),
      .wr_addr (a_arg_ff[DATA_AW-1:0]),
      .wr_data (cell_q[0]),
      .busy    (mem_busy)
   );

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic [WW-1:0] above;
      logic [WW-1:0] below;
      if (i == 0) begin : g_head
         assign above = stk_ctl.push_data;
      end else begin : g_mid
         assign above = cell_q[i-1];
      end
      if (i == NCELL - 1) begin : g_tail
         assign below = cell_q[i];
      end else begin : g_body
         assign below = cell_q[i+1];
      end
      sme_stack_cell u_cell (
         .clock      (clock),
         .ctl        (stk_ctl),
         .from_above (above),
         .from_below (below),
         .value      (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff  <= '0;
         a_valid_ff   <= 1'b0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) prog_len_ff <= csr_pwdata[sme_pkg::PC_W-1:0];
         if (accept) a_valid_ff <= 1'b1;
         else if (b_fire) a_valid_ff <= 1'b0;
         if (b_fire) begin
            pc_ff        <= pc_in;
            halted_ff    <= halted_in;
            depth_ff     <= depth_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_func_ff     <= req_tdata[sme_pkg::FUNC_W-1:0];
         a_arg_ff      <= req_tdata[sme_pkg::FUNC_W +: WW];
         a_fwd_hit_ff  <= fwd_hit_in;
         a_fwd_data_ff <= cell_q[0];
      end
      if (b_fire) begin
         rsp_data_ff <= {5'd0, depth_in, top_in, status, pc_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sim/sme_tb_pkg.sv =====
// Scoreboard for the stack machine execute block: shadow machine state and expected beats.
// Depends on sme_pkg for widths, opcodes and status codes.
package sme_tb_pkg;
   import sme_pkg::*;

   // Packed in beat order: next_pc in the low bits
   typedef struct packed {
      logic [COUNT_W-1:0] stack_count;
      logic [WORD_W-1:0]  top_value;
      status_type         status;
      logic [PC_W-1:0]    next_pc;
   } exec_result_type;

   class exec_scoreboard;
      logic [PC_W-1:0]   length_reg;
      logic [PC_W-1:0]   pc;
      bit                halted;
      int unsigned       depth;
      int unsigned       peak_depth;
      logic [WORD_W-1:0] stack_words [STACK_DEPTH];
      logic [WORD_W-1:0] data_words [DATA_DEPTH_DEF];
      exec_result_type   pending [$];
      int                errors;
      int                checked;
      int                executed;
      int                running_steps;
      int                first_stop;

      function new();
         length_reg    = '0;
         pc            = '0;
         halted        = 1'b0;
         depth         = 0;
         peak_depth    = 0;
         errors        = 0;
         checked       = 0;
         executed      = 0;
         running_steps = 0;
         first_stop    = -1;
         foreach (stack_words[i]) stack_words[i] = '0;
         foreach (data_words[i]) data_words[i] = '0;
      endfunction

      function int unsigned eff_length();
         return (length_reg > PROG_DEPTH) ? PROG_DEPTH : length_reg;
      endfunction

      function void set_length(logic [PC_W-1:0] value);
         length_reg = value;
      endfunction

      function logic [WORD_W-1:0] top_word();
         return (depth != 0) ? stack_words[depth-1] : '0;
      endfunction

      function void push_word(logic [WORD_W-1:0] value);
         stack_words[depth] = value;
         depth++;
         if (depth > peak_depth) peak_depth = depth;
      endfunction

      // Execute one instruction on the shadow machine and queue the beat it produces
      function void note_instr(logic [FUNC_W-1:0] fn, logic [WORD_W-1:0] arg);
         int unsigned     len;
         status_type      st;
         logic [PC_W-1:0] npc;
         logic [WORD_W-1:0] a, b, r;
         exec_result_type res;
         len = eff_length();
         st  = ST_RUN;
         npc = pc + 1'b1;
         a   = top_word();
         b   = (depth >= 2) ? stack_words[depth-2] : '0;
         if (halted || pc >= len) begin
            st = ST_HALT;
         end else begin
            case (fn)
               FN_RET: st = ST_HALT;
               FN_LD: begin
                  if (arg >= DATA_DEPTH_DEF) st = ST_ADDR;
                  else if (depth >= STACK_DEPTH) st = ST_OVER;
                  else push_word(data_words[arg]);
               end
               FN_ST: begin
                  // address check wins over an empty stack
                  if (arg >= DATA_DEPTH_DEF) st = ST_ADDR;
                  else if (depth == 0) st = ST_UNDER;
                  else begin
                     depth--;
                     data_words[arg] = stack_words[depth];
                  end
               end
               FN_LDC: begin
                  if (depth >= STACK_DEPTH) st = ST_OVER;
                  else push_word(arg);
               end
               FN_ADD, FN_SUB, FN_CMP: begin
                  if (depth < 2) st = ST_UNDER;
                  else if (depth >= STACK_DEPTH) st = ST_OVER;
                  else begin
                     if (fn == FN_ADD) r = a + b;
                     else if (fn == FN_SUB) r = a - b;
                     else if ($signed(a) < $signed(b)) r = 32'hFFFF_FFFF;
                     else if ($signed(a) > $signed(b)) r = 32'd1;
                     else r = 32'd0;
                     push_word(r);
                  end
               end
               FN_JMP: begin
                  if (arg >= len) st = ST_TARGET;
                  else npc = arg[PC_W-1:0];
               end
               FN_BR: begin
                  // target check wins over an empty stack; the top stays put
                  if (arg >= len) st = ST_TARGET;
                  else if (depth == 0) st = ST_UNDER;
                  else if (a != '0) npc = arg[PC_W-1:0];
               end
               default: st = ST_OPCODE;
            endcase
            if (st == ST_RUN) pc = npc;
            else halted = 1'b1;
         end
         if (st == ST_RUN) running_steps++;
         else if (first_stop < 0) first_stop = int'(st);
         res.next_pc     = pc;
         res.status      = st;
         res.top_value   = top_word();
         res.stack_count = COUNT_W'(depth);
         pending.push_back(res);
         executed++;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
      endtask

      task check_result(logic [RSP_TDATA_W-1:0] beat);
         exec_result_type want;
         logic [PC_W-1:0]     got_pc;
         logic [STATUS_W-1:0] got_status;
         logic [WORD_W-1:0]   got_top;
         logic [COUNT_W-1:0]  got_count;
         got_pc     = beat[PC_W-1:0];
         got_status = beat[PC_W +: STATUS_W];
         got_top    = beat[PC_W+STATUS_W +: WORD_W];
         got_count  = beat[PC_W+STATUS_W+WORD_W +: COUNT_W];
         checked++;
         if (pending.size() == 0) begin
            report($sformatf("result beat %0d arrived with no instruction waiting", checked));
            return;
         end
         want = pending.pop_front();
         if (got_pc != want.next_pc)
            report($sformatf("beat %0d next_pc %0d, want %0d", checked, got_pc, want.next_pc));
         if (got_status != want.status)
            report($sformatf("beat %0d status %0d, want %0d", checked, got_status,
                             want.status));
         if (got_top != want.top_value)
            report($sformatf("beat %0d top_value %h, want %h", checked, got_top,
                             want.top_value));
         if (got_count != want.stack_count)
            report($sformatf("beat %0d stack_count %0d, want %0d", checked, got_count,
                             want.stack_count));
      endtask
   endclass

endpackage

// ===== sim/stack_machine_execute_core_tb.sv =====
// Testbench top for stack_machine_execute_core: drives instruction beats and APB writes,
// checks every result beat. Depends on sme_pkg and the scoreboard in sme_tb_pkg.
module stack_machine_execute_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sme_pkg::*;
   import sme_tb_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER  = 600;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr   = '0;
   logic [CSR_DW-1:0]      csr_pwdata  = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   exec_scoreboard sb;
   bit             gaps_on      = 1'b1;
   int             push_bias    = 50;
   int             lengths_used = 0;

   stack_machine_execute_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check each beat, stall at random, one long hold-off to back up the core
   initial begin : result_sink
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (!hold_done && sb.checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !gaps_on || ($urandom_range(99) >= 20);
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stalled = 0;
         else stalled++;
      end
      $display("stack_machine_execute_core test failed");
      $finish;
   end

   task automatic send_instr(logic [FUNC_W-1:0] fn, logic [WORD_W-1:0] arg);
      if (gaps_on) begin
         while ($urandom_range(99) < 20) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-FUNC_W-WORD_W){1'b0}}, arg, fn};
      do @(posedge clock); while (!req_tready);
      sb.note_instr(fn, arg);
   endtask

   // Drop valid, let every expected beat drain, then cover the core's two-stage pipe
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_length(logic [PC_W-1:0] value);
      logic [CSR_DW-1:0] readback;
      wait_idle();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_PROGRAM_LENGTH;
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_length(value);
      lengths_used++;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback != CSR_DW'(value))
         sb.report($sformatf("program_length reads %0d, wrote %0d", readback, value));
   endtask

   function automatic logic [WORD_W-1:0] random_constant();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(15);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] random_address();
      return $urandom_range(1) ? $urandom_range(15) : $urandom_range(DATA_DEPTH_DEF - 1);
   endfunction

   function automatic logic [WORD_W-1:0] bad_address();
      case ($urandom_range(2))
         0: return DATA_DEPTH_DEF;
         1: return 32'h8000_0000 | $urandom();
         default: return DATA_DEPTH_DEF + $urandom_range(1 << 20);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] bad_target();
      case ($urandom_range(2))
         0: return sb.eff_length();
         1: return 32'h8000_0000 | $urandom();
         default: return sb.eff_length() + $urandom_range(1 << 20);
      endcase
   endfunction

   // One well-formed instruction: never faults, keeps pc inside the program
   task automatic random_step();
      int unsigned       len, depth, pick;
      logic [FUNC_W-1:0] fn;
      logic [WORD_W-1:0] arg;
      len   = sb.eff_length();
      depth = sb.depth;
      pick  = $urandom_range(99);
      arg   = $urandom();
      if (sb.pc == len - 1 || pick < 8) begin
         fn  = FN_JMP;
         arg = $urandom_range(len - 1);
      end else if (pick < 20 && depth > 0) begin
         fn  = FN_BR;
         arg = $urandom_range(len - 1);
      end else if ((($urandom_range(99) < push_bias) && depth < STACK_DEPTH) || depth == 0) begin
         case ($urandom_range(4))
            0: begin
               fn  = FN_LD;
               arg = random_address();
            end
            1: begin
               fn  = FN_LDC;
               arg = random_constant();
            end
            default: begin
               if (depth >= 2) begin
                  fn = FUNC_W'(FN_ADD + $urandom_range(2));
               end else begin
                  fn  = FN_LDC;
                  arg = random_constant();
               end
            end
         endcase
      end else begin
         fn  = FN_ST;
         arg = random_address();
      end
      send_instr(fn, arg);
   endtask

   task automatic drain_to(int unsigned floor_depth);
      while (sb.depth > floor_depth) send_instr(FN_ST, random_address());
   endtask

   // Stop the machine once, by a cause picked at random, then poke the halted core
   task automatic force_halt();
      write_length(PC_W'(PROG_DEPTH));
      case ($urandom_range(11))
         0: send_instr(FN_RET, $urandom());
         1: send_instr(FN_LD, bad_address());
         2: begin
            if ($urandom_range(1)) drain_to(0);
            send_instr(FN_ST, bad_address());
         end
         3: begin
            drain_to(0);
            send_instr(FN_ST, random_address());
         end
         4: begin
            if ($urandom_range(1)) drain_to(0);
            send_instr(FN_BR, bad_target());
         end
         5: begin
            drain_to(0);
            send_instr(FN_BR, $urandom_range(PROG_DEPTH - 1));
         end
         6: begin
            drain_to($urandom_range(1));
            send_instr(FUNC_W'(FN_ADD + $urandom_range(2)), $urandom());
         end
         7: begin
            while (sb.depth < STACK_DEPTH) send_instr(FN_LDC, random_constant());
            case ($urandom_range(2))
               0: send_instr(FN_LDC, random_constant());
               1: send_instr(FN_LD, random_address());
               default: send_instr(FUNC_W'(FN_ADD + $urandom_range(2)), $urandom());
            endcase
         end
         8: send_instr(FN_JMP, bad_target());
         9: send_instr(FUNC_W'($urandom_range(15, 9)), $urandom());
         10: begin
            // step off the end of the program
            send_instr(FN_JMP, PROG_DEPTH - 1);
            if (sb.depth == 0) send_instr(FN_LDC, random_constant());
            else send_instr(FN_ST, random_address());
         end
         default: write_length('0);
      endcase
      repeat (12) send_instr(FUNC_W'($urandom()), $urandom());
      write_length('0);
      repeat (6) send_instr(FUNC_W'($urandom()), $urandom());
      write_length(PC_W'(PROG_DEPTH));
      repeat (6) send_instr(FUNC_W'($urandom()), $urandom());
   endtask

   initial begin : stimulus
      int unsigned phase_len [8];
      int unsigned len, count;
      sb = new();
      phase_len = '{256, 511, 1, 37, 2, 300, 0, 256};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_length(PC_W'(PROG_DEPTH));
      send_instr(FN_LDC, 32'h7FFF_FFFF);
      send_instr(FN_LDC, 32'h8000_0000);
      send_instr(FN_ADD, $urandom());
      send_instr(FN_SUB, $urandom());
      send_instr(FN_CMP, $urandom());
      send_instr(FN_CMP, $urandom());
      send_instr(FN_LDC, 32'hFFFF_FFFF);
      send_instr(FN_LDC, 32'hFFFF_FFFF);
      send_instr(FN_CMP, $urandom());
      send_instr(FN_ST, DATA_DEPTH_DEF - 1);
      send_instr(FN_ST, 0);
      send_instr(FN_LD, DATA_DEPTH_DEF - 1);
      send_instr(FN_LD, 0);
      send_instr(FN_LD, 17);
      send_instr(FN_LDC, 0);
      send_instr(FN_BR, 3);
      send_instr(FN_LDC, 1);
      send_instr(FN_BR, 200);
      send_instr(FN_JMP, PROG_DEPTH - 1);
      send_instr(FN_JMP, 0);

      foreach (phase_len[p]) begin
         len   = (p == 6) ? $urandom_range(255, 3) : phase_len[p];
         count = (len <= 2) ? 30 : 250;
         gaps_on = (p != 5);
         write_length(PC_W'(len));
         for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) push_bias = $urandom_range(85, 15);
            random_step();
         end
         // park pc at zero so the next length always covers it
         send_instr(FN_JMP, 0);
      end
      gaps_on = 1'b1;

      force_halt();
      wait_idle();
      repeat (6) @(posedge clock);

      $display("executed %0d instructions under %0d length settings, stack depth up to %0d",
               sb.executed, lengths_used, sb.peak_depth);
      $display("%0d result beats checked, %0d running steps, first stop with status %0d",
               sb.checked, sb.running_steps, sb.first_stop);
      if (sb.errors == 0) begin
         $display("stack_machine_execute_core test passed");
      end else begin
         $display("stack_machine_execute_core test failed");
      end
      $finish;
   end

endmodule
